>>> design/tmv_pkg.sv
// tmv_pkg: shared types and constants for the ternary weight matrix-vector block.
// No dependencies; imported by every module of the block.
package tmv_pkg;

  // Sizing of the activation store and row counter
  localparam int unsigned MaxCols  = 4096;
  localparam int unsigned MaxRows  = 4096;
  localparam int unsigned Lanes    = 4;                      // codes per weight byte
  localparam int unsigned ColW     = $clog2(MaxCols);        // 12
  localparam int unsigned LaneW    = $clog2(Lanes);          // 2
  localparam int unsigned ChunkW   = ColW - LaneW;           // 10
  localparam int unsigned MaxChunk = MaxCols / Lanes;        // 1024
  localparam int unsigned RowW     = $clog2(MaxRows);        // 12

  // Field and register widths
  localparam int unsigned ActW     = 16;
  localparam int unsigned SumW     = 29;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 2;
  localparam int unsigned CprW     = 11;
  localparam int unsigned RowsCfgW = 13;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 1;

  // Command queue between front and back
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  // Ternary codes; the two other codes contribute nothing
  localparam logic [CodeW-1:0] CodeAdd = 2'd1;
  localparam logic [CodeW-1:0] CodeSub = 2'd2;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_WEIGHT = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHUNKS_PER_ROW = 1'b0,
    CFG_ROWS_IN_USE    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    action_e                action;
    logic [ColW-1:0]        activation_index;
    logic signed [ActW-1:0] activation_value;
    logic [ByteW-1:0]       weight_byte;
  } tmv_in_t;

  typedef struct packed {
    logic signed [SumW-1:0] row_sum;
    logic [RowW-1:0]        row_index;
    logic                   last_row;
  } tmv_out_t;

  // Classified work for the back end
  typedef struct packed {
    logic                   is_load;
    logic [ColW-1:0]        addr;     // load: column; weight: chunk * Lanes
    logic signed [ActW-1:0] value;
    logic [ByteW-1:0]       wbyte;
    logic                   eor;      // weight byte closes its row
    logic [RowW-1:0]        row;
    logic                   last;     // row closes the pass
  } tmv_cmd_t;

endpackage

>>> design/tmv_front.sv
// tmv_front: config registers, chunk/row position tracking and command classification.
// Depends on tmv_pkg.
module tmv_front import tmv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_reg_e            cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  tmv_in_t             item_i,
  output tmv_cmd_t            cmd_o
);

  logic [CprW-1:0]     cpr_q;
  logic [RowsCfgW-1:0] rows_q;
  logic [ChunkW-1:0]   chunk_q, chunk_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [CprW-1:0]     cpr_eff, chunk_inc;
  logic [RowsCfgW-1:0] rows_eff, row_inc;
  logic                eor, last;

  // Out-of-range register values clamp into range
  always_comb begin
    if (cpr_q == '0) begin
      cpr_eff = CprW'(1);
    end else if (cpr_q > CprW'(MaxChunk)) begin
      cpr_eff = CprW'(MaxChunk);
    end else begin
      cpr_eff = cpr_q;
    end
    if (rows_q == '0) begin
      rows_eff = RowsCfgW'(1);
    end else if (rows_q > RowsCfgW'(MaxRows)) begin
      rows_eff = RowsCfgW'(MaxRows);
    end else begin
      rows_eff = rows_q;
    end
  end

  assign chunk_inc = CprW'(chunk_q) + CprW'(1);
  assign row_inc   = RowsCfgW'(row_q) + RowsCfgW'(1);
  assign eor       = (chunk_inc >= cpr_eff);
  assign last      = (row_inc >= rows_eff);

  always_comb begin
    chunk_d = chunk_q;
    row_d   = row_q;
    if (item_i.action == ACT_LOAD) begin
      chunk_d = '0;
      row_d   = '0;
    end else if (eor) begin
      chunk_d = '0;
      row_d   = last ? '0 : row_inc[RowW-1:0];
    end else begin
      chunk_d = chunk_inc[ChunkW-1:0];
    end
  end

  always_comb begin
    cmd_o.is_load = (item_i.action == ACT_LOAD);
    cmd_o.addr    = (item_i.action == ACT_LOAD) ? item_i.activation_index
                                                : {chunk_q, LaneW'(0)};
    cmd_o.value   = item_i.activation_value;
    cmd_o.wbyte   = item_i.weight_byte;
    cmd_o.eor     = eor;
    cmd_o.row     = row_q;
    cmd_o.last    = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q   <= CprW'(MaxChunk);
      rows_q  <= RowsCfgW'(MaxRows);
      chunk_q <= '0;
      row_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CHUNKS_PER_ROW: cpr_q  <= cfg_data_i[CprW-1:0];
          CFG_ROWS_IN_USE:    rows_q <= cfg_data_i[RowsCfgW-1:0];
          default:            ;
        endcase
      end
      if (accept_i) begin
        chunk_q <= chunk_d;
        row_q   <= row_d;
      end
    end
  end

endmodule

>>> design/tmv_cmd_queue.sv
// tmv_cmd_queue: short FIFO of classified commands between front and back.
// Depends on tmv_pkg.
module tmv_cmd_queue import tmv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  tmv_cmd_t wdata_i,
  output logic     full_o,
  input  logic     rd_i,
  output tmv_cmd_t rdata_o,
  output logic     avail_o
);

  tmv_cmd_t         mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign avail_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + QPtrW'(1);
      if (rd_i) rptr_q <= rptr_q + QPtrW'(1);
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + (QPtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPtrW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> design/tmv_back.sv
// tmv_back: activation store, four-lane ternary accumulate and two-entry result queue.
// Depends on tmv_pkg.
module tmv_back import tmv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     avail_i,
  input  tmv_cmd_t cmd_i,
  output logic     take_o,
  output logic     empty,
  input  logic     pop,
  output tmv_out_t result_o
);

  // Store row = one weight byte's worth of activations
  logic [Lanes-1:0][ActW-1:0] act_mem [MaxChunk];
  logic [Lanes-1:0][ActW-1:0] rd_q;

  logic                   b_valid_q;
  logic                   b_load_q, b_eor_q, b_last_q;
  logic [ByteW-1:0]       b_wbyte_q;
  logic [RowW-1:0]        b_row_q;
  logic signed [SumW-1:0] acc_q;
  logic signed [SumW-1:0] term [Lanes];
  logic signed [SumW-1:0] sum;
  logic                   b_go, adv, of_push, of_pop, of_full;

  tmv_out_t  ofq_q [2];
  logic      of_wptr_q, of_rptr_q;
  logic [1:0] of_cnt_q;

  assign of_full = (of_cnt_q == 2'd2);
  assign b_go    = !(b_valid_q && !b_load_q && b_eor_q && of_full);
  assign adv     = avail_i && (!b_valid_q || b_go);
  assign take_o  = adv;
  assign of_push = b_valid_q && b_go && !b_load_q && b_eor_q;
  assign of_pop  = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (adv && cmd_i.is_load) begin
      act_mem[cmd_i.addr[ColW-1:LaneW]][cmd_i.addr[LaneW-1:0]] <= cmd_i.value;
    end
    if (adv && !cmd_i.is_load) begin
      rd_q <= act_mem[cmd_i.addr[ColW-1:LaneW]];
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      case (b_wbyte_q[l*CodeW +: CodeW])
        CodeAdd: term[l] = SumW'(signed'(rd_q[l]));
        CodeSub: term[l] = -SumW'(signed'(rd_q[l]));
        default: term[l] = '0;
      endcase
    end
    sum = acc_q + ((term[0] + term[1]) + (term[2] + term[3]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_load_q  <= cmd_i.is_load;
      b_eor_q   <= cmd_i.eor;
      b_last_q  <= cmd_i.last;
      b_wbyte_q <= cmd_i.wbyte;
      b_row_q   <= cmd_i.row;
    end
    if (of_push) begin
      ofq_q[of_wptr_q] <= '{row_sum: sum, row_index: b_row_q, last_row: b_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      acc_q     <= '0;
      of_wptr_q <= 1'b0;
      of_rptr_q <= 1'b0;
      of_cnt_q  <= '0;
    end else begin
      if (adv) begin
        b_valid_q <= 1'b1;
      end else if (b_go) begin
        b_valid_q <= 1'b0;
      end
      if (b_valid_q && b_go) begin
        acc_q <= (b_load_q || b_eor_q) ? '0 : sum;
      end
      if (of_push) of_wptr_q <= !of_wptr_q;
      if (of_pop)  of_rptr_q <= !of_rptr_q;
      case ({of_push, of_pop})
        2'b10:   of_cnt_q <= of_cnt_q + 2'd1;
        2'b01:   of_cnt_q <= of_cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  assign empty    = (of_cnt_q == '0);
  assign result_o = ofq_q[of_rptr_q];

endmodule

>>> design/ternary_weight_matvec.sv
// ternary_weight_matvec: top level of the ternary weight matrix-vector product.
// Depends on tmv_pkg, tmv_front, tmv_cmd_queue, tmv_back.
//
// Usage
//   Input queue: item_i is taken on a clock edge with push high and full low.
//   action 0 writes activation_value into column activation_index and restarts
//   the pass; action 1 supplies one weight byte (four 2-bit codes, low bits
//   first; 1 adds, 2 subtracts, 0 and 3 skip).
//   Result queue: while empty is low the oldest row result sits on result_o;
//   it is transferred on an edge with pop high. A result follows the last byte
//   of each row and carries the 29-bit exact sum, row index and last-row flag.
//   Config: cfg_we_i writes chunks_per_row (index 0) or rows_in_use (index 1);
//   write only while idle. Out-of-range values clamp into range; chunks_per_row first keeps only its low 11 bits.
// Timing
//   One item per cycle sustained while the receiver keeps popping results. With the
//   back end idle, a row's final byte passes the command queue, then the store
//   read, then the accumulate into the result queue. The activation store is one
//   single-port-read memory row of four lanes per weight byte.
// Reset and stalls
//   Reset clears counters, accumulator and both queues; the store is not
//   cleared. If the receiver stalls, results back up into a two-entry queue,
//   the back end holds, the four-entry command queue fills and full goes high.
module ternary_weight_matvec import tmv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  tmv_in_t             item_i,
  output logic                empty,
  input  logic                pop,
  output tmv_out_t            result_o,
  input  logic                cfg_we_i,
  input  cfg_reg_e            cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic     accept;    // input transfer
  logic     take;      // back end consumes queue head
  logic     avail;
  tmv_cmd_t cmd_in, cmd_head;

  assign accept = push && !full;

  // Front: track row/chunk position and classify
  tmv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (item_i),
    .cmd_o      (cmd_in)
  );

  // Decouples input acceptance from back-end stalls
  tmv_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (cmd_in),
    .full_o  (full),
    .rd_i    (take),
    .rdata_o (cmd_head),
    .avail_o (avail)
  );

  // Back: store writes, lane reads, accumulate, result queue
  tmv_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (avail),
    .cmd_i    (cmd_head),
    .take_o   (take),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

endmodule

>>> design/tmv_checker.sv
// tmv_checker: port-level assertions for ternary_weight_matvec, bound to the top level.
// Depends on tmv_pkg.
module tmv_checker import tmv_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input tmv_out_t result_o
);

  // Reset leaves both queues empty
  a_reset_clear: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queues not clear in reset");

  // full can only rise after an input transfer
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push |=> !$rose(full))
    else $error("full rose without a push");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed");

endmodule

bind ternary_weight_matvec tmv_checker u_tmv_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

>>> tb/tb_ternary_weight_matvec.sv
// tb_ternary_weight_matvec: self-checking testbench for the ternary weight matrix-vector block.
// Depends on tmv_pkg and ternary_weight_matvec; holds its own row-sum predictor and checker.
// Run covers code mix, large sums, register clamping, row sweep, stalls and random traffic.
module tb_ternary_weight_matvec;
  import tmv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles the block may still be busy after the last expected row has arrived
  // (command queue, store read, accumulate, result queue), with margin.
  localparam int DrainCycles = 12;
  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the forced output hold (HoldCycles) plus some drain.
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 4000;
  localparam int IdlePercent = 37;
  localparam int RandPhases  = 8;
  localparam int PhaseItems  = 84;
  localparam int ScaleCols   = 128;   // columns loaded at the negative extreme
  localparam int SweepRows   = 512;   // pass length of the row sweep

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                push;
  logic                full;
  tmv_in_t             item;
  logic                empty;
  logic                pop = 1'b0;
  tmv_out_t            result;
  logic                cfg_we;
  cfg_reg_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  // Predictor state: activation store, pass position, running sum, registers.
  logic signed [ActW-1:0] act_mem [MaxCols];
  int unsigned            chunk_pos = 0;
  int unsigned            row_pos   = 0;
  longint                 row_acc   = 0;
  logic [CprW-1:0]        cpr_cfg   = CprW'(MaxChunk);
  logic [RowsCfgW-1:0]    rows_cfg  = RowsCfgW'(MaxRows);

  // Rows predicted but not yet transferred out, oldest first.
  tmv_out_t pending_rows [$];
  tmv_out_t want;

  int  n_errors    = 0;
  int  n_items     = 0;
  int  n_rows      = 0;
  int  quiet_cycles = 0;
  int  hold_req    = 0;   // set by a test, picked up by the result side
  int  hold_left   = 0;
  bit  no_idle     = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ternary_weight_matvec dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor: advances the pass by one accepted item and queues the finished
  // row, if any. Register values are clamped into range on use, so a change
  // mid-pass takes effect at the next comparison against chunk/row position.
  // ---------------------------------------------------------------------------
  task automatic accumulate_item(input tmv_in_t it);
    int unsigned     cpr;
    int unsigned     rows;
    logic [CodeW-1:0] code;
    tmv_out_t        res;
    cpr  = (cpr_cfg == 0) ? 1 : ((cpr_cfg > MaxChunk) ? MaxChunk : cpr_cfg);
    rows = (rows_cfg == 0) ? 1 : ((rows_cfg > MaxRows) ? MaxRows : rows_cfg);
    if (it.action == ACT_LOAD) begin
      // load writes one column and restarts the pass
      act_mem[it.activation_index] = it.activation_value;
      chunk_pos = 0;
      row_pos   = 0;
      row_acc   = 0;
      return;
    end
    for (int lane = 0; lane < Lanes; lane++) begin
      code = it.weight_byte[lane*CodeW +: CodeW];
      if (code == CodeAdd) row_acc += act_mem[chunk_pos*Lanes + lane];
      else if (code == CodeSub) row_acc -= act_mem[chunk_pos*Lanes + lane];
    end
    if (chunk_pos + 1 < cpr) begin
      chunk_pos++;
      return;
    end
    res.row_sum   = row_acc[SumW-1:0];
    res.row_index = row_pos[RowW-1:0];
    res.last_row  = (row_pos + 1 >= rows);
    pending_rows.push_back(res);
    row_acc   = 0;
    chunk_pos = 0;
    row_pos   = res.last_row ? 0 : row_pos + 1;
  endtask

  // ---------------------------------------------------------------------------
  // Item builders; fields the action ignores still carry random bits.
  // ---------------------------------------------------------------------------
  function automatic tmv_in_t load_item(input logic [ColW-1:0] col,
                                        input logic signed [ActW-1:0] val);
    tmv_in_t it;
    it.action           = ACT_LOAD;
    it.activation_index = col;
    it.activation_value = val;
    it.weight_byte      = ByteW'($urandom);
    return it;
  endfunction

  function automatic tmv_in_t weight_item(input logic [ByteW-1:0] wb);
    tmv_in_t it;
    it.action           = ACT_WEIGHT;
    it.activation_index = ColW'($urandom);
    it.activation_value = ActW'($urandom);
    it.weight_byte      = wb;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: random idle cycles, then hold push until the transfer happens.
  // full is sampled right after the edge, i.e. its value at that edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input tmv_in_t it);
    while (!no_idle && $urandom_range(99) < IdlePercent) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item <= it;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    n_items++;
    accumulate_item(it);
  endtask

  // Wait until every predicted row is out and the pipeline has drained.
  task automatic settle();
    push <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Both registers, back to back; call only after settle().
  task automatic configure(input logic [CfgDataW-1:0] cpr_val,
                           input logic [CfgDataW-1:0] rows_val);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_CHUNKS_PER_ROW;
    cfg_data <= cpr_val;
    @(posedge clk_i);
    cpr_cfg  = cpr_val[CprW-1:0];
    cfg_idx  <= CFG_ROWS_IN_USE;
    cfg_data <= rows_val;
    @(posedge clk_i);
    rows_cfg = rows_val[RowsCfgW-1:0];
    cfg_we   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: compare each transfer with the oldest prediction, then pick
  // the next pop (forced hold, random idle, or ready).
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_rows++;
        if (pending_rows.size() == 0) begin
          $error("unexpected row result: row_index %0d row_sum %0d",
                 result.row_index, result.row_sum);
          n_errors++;
        end else begin
          want = pending_rows.pop_front();
          if (result.row_sum !== want.row_sum) begin
            $error("row_sum: expected %0d, got %0d", want.row_sum, result.row_sum);
            n_errors++;
          end
          if (result.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, result.row_index);
            n_errors++;
          end
          if (result.last_row !== want.last_row) begin
            $error("last_row: expected %0b, got %0b", want.last_row, result.last_row);
            n_errors++;
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_ternary_weight_matvec: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All four codes, both actions, value extremes, restart by a load mid-pass,
  // end-of-pass wrap. Only columns loaded here are ever read.
  task automatic test_directed_codes();
    configure(1, 3);
    send_item(load_item(0, 16'sd32767));
    send_item(load_item(1, -16'sd32768));
    send_item(load_item(2, 16'sd1));
    send_item(load_item(3, -16'sd1));
    send_item(weight_item(8'h55));   // all add
    send_item(weight_item(8'hAA));   // all subtract
    send_item(weight_item(8'h00));   // all skip; closes the pass
    send_item(weight_item(8'hFF));   // code 3 everywhere skips; pass wrapped to row 0
    send_item(weight_item(8'h1B));   // codes 3,2,1,0 low lane first
    send_item(load_item(2, 16'sd5)); // restart mid-pass
    send_item(weight_item(8'h10));
    settle();
    configure(2, 2);
    send_item(load_item(4, 16'sd100));
    send_item(load_item(5, -16'sd200));
    send_item(load_item(6, 16'sd300));
    send_item(load_item(7, 16'sd32767));
    send_item(weight_item(8'h99));   // chunk 0: add/sub alternating
    send_item(weight_item(8'h66));   // chunk 1 closes the row
    settle();
  endtask

  // Many columns at the negative extreme over long rows: sums reach +/- 2^22.
  // Afterwards the low columns get random values for the later tests.
  task automatic test_full_scale_sum();
    configure(CfgDataW'(ScaleCols / Lanes), 2);
    for (int c = 0; c < ScaleCols; c++) send_item(load_item(ColW'(c), -16'sd32768));
    repeat (ScaleCols / Lanes) send_item(weight_item(8'hAA));
    repeat (ScaleCols / Lanes) send_item(weight_item(8'h55));
    for (int c = 0; c < 32; c++) send_item(load_item(ColW'(c), ActW'($urandom)));
    settle();
  endtask

  // Zero register values, then upper data bits set and rows_in_use above range.
  task automatic test_register_clamp();
    configure(0, 0);
    repeat (3) send_item(weight_item(ByteW'($urandom)));
    settle();
    configure(13'h1820, 13'h1FFF);   // chunks_per_row keeps its low bits: 32
    repeat (64) send_item(weight_item(ByteW'($urandom)));
    settle();
  endtask

  // One byte per row through a long pass and into the wrap, back to back.
  task automatic test_row_index_sweep();
    configure(1, CfgDataW'(SweepRows));
    send_item(load_item(0, ActW'($urandom)));
    no_idle = 1'b1;
    repeat (SweepRows + 1) send_item(weight_item(ByteW'($urandom)));
    no_idle = 1'b0;
    settle();
  endtask

  // Shrink chunks_per_row below the current chunk position, then rows_in_use
  // below the current row: both must close at once.
  task automatic test_midpass_reconfig();
    configure(8, 3);
    send_item(load_item(1, ActW'($urandom)));
    repeat (5) send_item(weight_item(ByteW'($urandom)));
    settle();
    configure(2, 3);
    send_item(weight_item(ByteW'($urandom)));   // row 0 ends here
    send_item(weight_item(ByteW'($urandom)));
    settle();
    configure(2, 1);
    repeat (2) send_item(weight_item(ByteW'($urandom)));   // row 1 ends the pass
    repeat (4) send_item(weight_item(ByteW'($urandom)));
    settle();
  endtask

  // Receiver holds off long enough for both internal queues to fill and full
  // to rise while the sender keeps offering one-byte rows.
  task automatic test_result_backpressure();
    configure(1, 7);
    hold_req = HoldCycles;
    no_idle  = 1'b1;
    repeat (40) send_item(weight_item(ByteW'($urandom)));
    no_idle  = 1'b0;
    settle();
  endtask

  // Random phases: small rows and passes so results are frequent, occasional
  // loads (half aimed at the columns in use), one phase without idling.
  task automatic test_random_traffic();
    logic [CfgDataW-1:0] cpr_val;
    logic [CfgDataW-1:0] rows_val;
    for (int p = 0; p < RandPhases; p++) begin
      cpr_val  = CfgDataW'($urandom_range(0, 6));
      rows_val = CfgDataW'($urandom_range(0, 5));
      if ($urandom_range(3) == 0) cpr_val[CfgDataW-1:CprW] = 2'($urandom);
      if ($urandom_range(3) == 0) rows_val = CfgDataW'($urandom);
      configure(cpr_val, rows_val);
      no_idle = (p == 3);
      repeat (PhaseItems) begin
        if ($urandom_range(99) < 10) begin
          if ($urandom_range(1) == 0)
            send_item(load_item(ColW'($urandom_range(0, 31)), ActW'($urandom)));
          else
            send_item(load_item(ColW'($urandom), ActW'($urandom)));
        end else begin
          send_item(weight_item(ByteW'($urandom)));
        end
      end
      no_idle = 1'b0;
      settle();
    end
  endtask

  initial begin
    rst_ni   = 1'b1;
    push     = 1'b0;
    item     = '0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_CHUNKS_PER_ROW;
    cfg_data = '0;
    #1 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_codes();
    test_full_scale_sum();
    test_register_clamp();
    test_row_index_sweep();
    test_midpass_reconfig();
    test_result_backpressure();
    test_random_traffic();

    // settle() above already drained; a further drain wait catches stray results
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_rows.size() != 0) begin
      $error("%0d predicted rows never transferred", pending_rows.size());
      n_errors++;
    end
    $display("Run: %0d input transfers, %0d row results checked.", n_items, n_rows);
    $display("Covered code mix, large sums, clamping, row sweep, reconfig, stall, random.");
    if (n_errors == 0) begin
      $display("tb_ternary_weight_matvec: clean");
    end else begin
      $display("tb_ternary_weight_matvec: errors");
    end
    $finish;
  end

endmodule

>>> ternary_weight_matvec.f
design/tmv_pkg.sv
design/tmv_front.sv
design/tmv_cmd_queue.sv
design/tmv_back.sv
design/ternary_weight_matvec.sv
design/tmv_checker.sv
tb/tb_ternary_weight_matvec.sv
